// ===== rtl/crt_pkg.sv =====
// content registry table: shared constants and types
// no dependencies
package crt_pkg;

  localparam int MAX_ENTRIES = 8;
  localparam int NAME_BYTES  = 8;

  localparam logic [1:0] CMD_REGISTER   = 2'd0;
  localparam logic [1:0] CMD_LIST       = 2'd1;
  localparam logic [1:0] CMD_DEREGISTER = 2'd2;
  localparam logic [1:0] CMD_SEARCH     = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EXISTS     = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_NO_CONTENT = 3'd4;

  typedef struct packed {
    logic [63:0] owner;
    logic [63:0] item;
    logic [31:0] addr;
    logic [15:0] port;
  } entry_t;

endpackage

// ===== rtl/crt_cell.sv =====
// content registry table: one storage cell of the rotating chain
// depends on crt_pkg
module crt_cell (
  input  logic            clk,
  input  logic            shift,
  input  logic            load,
  input  crt_pkg::entry_t load_entry,
  input  crt_pkg::entry_t prev_entry,
  output crt_pkg::entry_t entry
);

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= prev_entry;
    end
  end

endmodule

// ===== rtl/content_registry_table.sv =====
// content registry table: top level with sequencer and cell chain
// depends on crt_pkg and crt_cell
//
// Entries sit in a chain of MAX_ENTRIES cells that closes into a ring. While a
// command runs, the ring turns one place per cycle and the sequencer compares
// only the entry in the head cell. Register, deregister and search each pass
// through an accept state, a full turn of the ring and a settle state. The
// result word is registered in the settle state, and the next command can be
// taken in the cycle after the result leaves. A list over n entries turns the
// ring once per entry, and each result word before the last passes through its
// own output state. A list gives one word per distinct content name, or one
// no-content word when the table is empty; every other command gives one word.
// Input stays stalled while a command runs and while its result words wait.
// Deregister shifts the later entries down one cell in the settle state.
module content_registry_table #(
  parameter int MAX_ENTRIES = crt_pkg::MAX_ENTRIES,
  parameter int NAME_BYTES  = crt_pkg::NAME_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] peer_name,
  input  logic [63:0] content_name,
  input  logic [31:0] peer_address,
  input  logic [15:0] peer_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] found_address,
  output logic [15:0] found_port,
  output logic [63:0] listed_name,
  output logic        last
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [63:0] NAME_MASK = {64{1'b1}} >> (64 - 8 * NAME_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;
  localparam logic [2:0] S_LIST  = 3'd4;
  localparam logic [2:0] S_LDEC  = 3'd5;
  localparam logic [2:0] S_LNEXT = 3'd6;
  localparam logic [2:0] S_LOUT  = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [IW-1:0] step;
  logic [CW-1:0] step_c;
  logic [1:0]    op;
  logic [63:0]   key_peer;
  logic [63:0]   key_item;
  logic [31:0]   key_addr;
  logic [15:0]   key_port;
  logic          hit;
  logic [IW-1:0] hit_pos;
  logic [31:0]   hit_addr;
  logic [15:0]   hit_port;
  logic [CW-1:0] outer;
  logic          seen;
  logic [63:0]   cand;
  logic [63:0]   next_cand;
  logic          have_pend;
  logic [63:0]   pend_name;

  crt_pkg::entry_t cells [MAX_ENTRIES];
  crt_pkg::entry_t head;
  crt_pkg::entry_t new_entry;
  logic            rot;
  logic            ins;
  logic            drop;
  logic            last_step;
  logic            in_range;

  assign head = cells[0];
  assign new_entry = '{owner: key_peer, item: key_item, addr: key_addr, port: key_port};

  // ring: cell i takes from cell i+1, tail takes from head
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    crt_cell u_cell (
      .clk        (clk),
      .shift      (rot || (drop && (hit_pos <= IW'(g)))),
      .load       (ins && (count == CW'(g))),
      .load_entry (new_entry),
      .prev_entry (cells[(g + 1) % MAX_ENTRIES]),
      .entry      (cells[g])
    );
  end

  assign step_c    = CW'(step);
  assign last_step = (step == IW'(MAX_ENTRIES - 1));
  assign in_range  = step_c < count;
  assign in_stall  = (state != S_IDLE);
  assign rot       = (state == S_SCAN) || (state == S_LIST);
  assign ins       = (state == S_FIN) && (op == crt_pkg::CMD_REGISTER) && !hit &&
                     (count != CW'(MAX_ENTRIES));
  assign drop      = (state == S_FIN) && (op == crt_pkg::CMD_DEREGISTER) && hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= cmd;
            key_peer <= peer_name & NAME_MASK;
            key_item <= content_name & NAME_MASK;
            key_addr <= peer_address;
            key_port <= peer_port;
            hit      <= 1'b0;
            step     <= '0;
            if (cmd == crt_pkg::CMD_LIST) begin
              if (count == '0) begin
                status        <= crt_pkg::ST_NO_CONTENT;
                found_address <= '0;
                found_port    <= '0;
                listed_name   <= '0;
                last          <= 1'b1;
                out_valid     <= 1'b1;
                state         <= S_OUT;
              end else begin
                outer     <= '0;
                seen      <= 1'b0;
                have_pend <= 1'b0;
                cand      <= head.item;
                state     <= S_LIST;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (in_range) begin
            if (op == crt_pkg::CMD_SEARCH) begin
              if (head.item == key_item) begin
                hit      <= 1'b1;
                hit_addr <= head.addr;
                hit_port <= head.port;
              end
            end else if (head.owner == key_peer) begin
              hit     <= 1'b1;
              hit_pos <= step;
            end
          end
          step <= last_step ? '0 : step + 1'b1;
          if (last_step) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          found_address <= (op == crt_pkg::CMD_SEARCH && hit) ? hit_addr : '0;
          found_port    <= (op == crt_pkg::CMD_SEARCH && hit) ? hit_port : '0;
          listed_name   <= '0;
          last          <= 1'b1;
          out_valid     <= 1'b1;
          state         <= S_OUT;
          case (op)
            crt_pkg::CMD_REGISTER: begin
              if (hit) begin
                status <= crt_pkg::ST_EXISTS;
              end else if (count == CW'(MAX_ENTRIES)) begin
                status <= crt_pkg::ST_FULL;
              end else begin
                status <= crt_pkg::ST_OK;
                count  <= count + 1'b1;
              end
            end
            crt_pkg::CMD_DEREGISTER: begin
              if (hit) begin
                status <= crt_pkg::ST_OK;
                count  <= count - 1'b1;
              end else begin
                status <= crt_pkg::ST_NOT_FOUND;
              end
            end
            crt_pkg::CMD_SEARCH: begin
              status <= hit ? crt_pkg::ST_OK : crt_pkg::ST_NOT_FOUND;
            end
            default: status <= crt_pkg::ST_NOT_FOUND;
          endcase
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_LIST: begin
          // candidate against every earlier entry, next candidate picked up on the way
          if (step_c < outer && head.item == cand) begin
            seen <= 1'b1;
          end
          if (step_c == outer + 1'b1) begin
            next_cand <= head.item;
          end
          step <= last_step ? '0 : step + 1'b1;
          if (last_step) begin
            state <= S_LDEC;
          end
        end
        S_LDEC: begin
          if (!seen && have_pend) begin
            status        <= crt_pkg::ST_OK;
            found_address <= '0;
            found_port    <= '0;
            listed_name   <= pend_name;
            last          <= 1'b0;
            out_valid     <= 1'b1;
            pend_name     <= cand;
            state         <= S_LOUT;
          end else begin
            if (!seen) begin
              pend_name <= cand;
              have_pend <= 1'b1;
            end
            state <= S_LNEXT;
          end
        end
        S_LOUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_LNEXT;
          end
        end
        S_LNEXT: begin
          if (outer + 1'b1 >= count) begin
            status        <= crt_pkg::ST_OK;
            found_address <= '0;
            found_port    <= '0;
            listed_name   <= pend_name;
            last          <= 1'b1;
            out_valid     <= 1'b1;
            state         <= S_OUT;
          end else begin
            outer <= outer + 1'b1;
            cand  <= next_cand;
            seen  <= 1'b0;
            state <= S_LIST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES));

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_address) &&
      $stable(found_port) && $stable(listed_name) && $stable(last));

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= crt_pkg::ST_NO_CONTENT);

endmodule

// ===== test/tb_top.sv =====
// testbench for content_registry_table: directed and random register, list,
// deregister and search words checked against an in-bench table predictor
// depends on crt_pkg and the rtl of content_registry_table
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCH_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cmd;
  logic [63:0] peer_name;
  logic [63:0] content_name;
  logic [31:0] peer_address;
  logic [15:0] peer_port;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [31:0] found_address;
  logic [15:0] found_port;
  logic [63:0] listed_name;
  logic        last;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] name;
    logic        last;
  } reply_t;

  reply_t replies_due[$];
  crt_pkg::entry_t table_copy[crt_pkg::MAX_ENTRIES];
  int     used;
  int     errors;
  int     idle_cycles;
  bit     hold_out;
  bit     gaps_on;
  logic [63:0] peer_pool[6];
  logic [63:0] item_pool[4];

  content_registry_table dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int owner_index(input logic [63:0] p);
    for (int i = 0; i < used; i++)
      if (table_copy[i].owner == p) return i;
    return -1;
  endfunction

  task automatic predict_registry(input logic [1:0] c, input logic [63:0] p,
                                  input logic [63:0] it, input logic [31:0] a,
                                  input logic [15:0] pt);
    reply_t r;
    int idx;
    bit seen;
    r = '0;
    r.last = 1;
    case (c)
      crt_pkg::CMD_REGISTER: begin
        if (owner_index(p) >= 0) r.status = crt_pkg::ST_EXISTS;
        else if (used >= crt_pkg::MAX_ENTRIES) r.status = crt_pkg::ST_FULL;
        else begin
          table_copy[used] = '{owner: p, item: it, addr: a, port: pt};
          used++;
          r.status = crt_pkg::ST_OK;
        end
        replies_due.push_back(r);
      end
      crt_pkg::CMD_LIST: begin
        if (used == 0) begin
          r.status = crt_pkg::ST_NO_CONTENT;
          replies_due.push_back(r);
        end else begin
          for (int i = 0; i < used; i++) begin
            seen = 0;
            for (int j = 0; j < i; j++)
              if (table_copy[j].item == table_copy[i].item) seen = 1;
            if (!seen) begin
              r.status = crt_pkg::ST_OK;
              r.name = table_copy[i].item;
              r.last = 0;
              replies_due.push_back(r);
            end
          end
          replies_due[$].last = 1;
        end
      end
      crt_pkg::CMD_DEREGISTER: begin
        idx = owner_index(p);
        if (idx < 0) r.status = crt_pkg::ST_NOT_FOUND;
        else begin
          for (int i = idx; i + 1 < used; i++) table_copy[i] = table_copy[i + 1];
          used--;
          r.status = crt_pkg::ST_OK;
        end
        replies_due.push_back(r);
      end
      default: begin
        r.status = crt_pkg::ST_NOT_FOUND;
        for (int i = used - 1; i >= 0; i--)
          if (table_copy[i].item == it) begin
            r.status = crt_pkg::ST_OK;
            r.addr = table_copy[i].addr;
            r.port = table_copy[i].port;
            break;
          end
        replies_due.push_back(r);
      end
    endcase
  endtask

  task automatic send_word(input logic [1:0] c, input logic [63:0] p,
                           input logic [63:0] it, input logic [31:0] a,
                           input logic [15:0] pt);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    repeat (gap) @(negedge clk);
    in_valid = 1;
    cmd = c;
    peer_name = p;
    content_name = it;
    peer_address = a;
    peer_port = pt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_registry(c, p, it, a, pt);
    @(negedge clk);
    in_valid = 0;
  endtask

  // receiver: random stalls while gaps are on, unless held off
  initial begin
    int wait_n;
    out_stall = 1;
    @(negedge clk);
    forever begin
      if (hold_out) begin
        out_stall <= 1;
        @(negedge clk);
      end else begin
        wait_n = gaps_on ? $urandom_range(0, 14) : 0;
        if (wait_n > 0) begin
          out_stall <= 1;
          repeat (wait_n) @(negedge clk);
        end
        out_stall <= 0;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    reply_t w;
    if (!rst && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report("unexpected word", '0, '0);
      end else begin
        w = replies_due.pop_front();
        if (status !== w.status) report("status", 64'(status), 64'(w.status));
        if (found_address !== w.addr)
          report("found_address", 64'(found_address), 64'(w.addr));
        if (found_port !== w.port) report("found_port", 64'(found_port), 64'(w.port));
        if (listed_name !== w.name) report("listed_name", listed_name, w.name);
        if (last !== w.last) report("last", 64'(last), 64'(w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (replies_due.size() != 0) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_word(crt_pkg::CMD_LIST, '0, '0, '0, '0);
    send_word(crt_pkg::CMD_SEARCH, '0, '0, '0, '0);
    send_word(crt_pkg::CMD_DEREGISTER, '0, '0, '0, '0);
    send_word(crt_pkg::CMD_REGISTER, '1, '1, '1, '1);
    send_word(crt_pkg::CMD_REGISTER, '1, 64'd5, 32'd1, 16'd1);
    send_word(crt_pkg::CMD_REGISTER, '0, '0, '0, '0);
    for (int i = 1; i <= 6; i++)
      send_word(crt_pkg::CMD_REGISTER, 64'h100 + i, (i % 2) ? 64'h0 : '1,
                32'h1000 + i, 16'(i));
    send_word(crt_pkg::CMD_REGISTER, 64'h999, 64'd1, 32'd2, 16'd3);
    send_word(crt_pkg::CMD_LIST, '0, '0, '0, '0);
    send_word(crt_pkg::CMD_SEARCH, '0, '1, '0, '0);
    send_word(crt_pkg::CMD_SEARCH, '0, 64'h77, '0, '0);
    send_word(crt_pkg::CMD_DEREGISTER, '1, '0, '0, '0);
    send_word(crt_pkg::CMD_DEREGISTER, 64'h555, '0, '0, '0);
    send_word(crt_pkg::CMD_SEARCH, '0, '1, '0, '0);
    send_word(crt_pkg::CMD_LIST, '0, '0, '0, '0);
    for (int i = 0; i < 7; i++)
      send_word(crt_pkg::CMD_DEREGISTER, (i == 0) ? 64'h0 : 64'h100 + i, '0, '0, '0);
    send_word(crt_pkg::CMD_LIST, '0, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random();
    logic [1:0] c;
    for (int k = 0; k < 110; k++) begin
      c = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0)
        send_word(c, rnd64(), rnd64(), $urandom, 16'($urandom));
      else
        send_word(c, peer_pool[$urandom_range(0, 5)], item_pool[$urandom_range(0, 3)],
                  $urandom, 16'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int hold_n;
    hold_n = 300;
    fork
      begin
        hold_out = 1;
        repeat (hold_n) @(negedge clk);
        hold_out = 0;
      end
      for (int k = 0; k < 12; k++)
        send_word((k % 3 == 0) ? crt_pkg::CMD_LIST : crt_pkg::CMD_REGISTER, peer_pool[k % 6],
                  item_pool[k % 4], $urandom, 16'($urandom));
    join
    wait_drained();
  endtask

  initial begin
    errors = 0;
    used = 0;
    hold_out = 0;
    gaps_on = 0;
    rst = 1;
    in_valid = 0;
    cmd = 0;
    peer_name = 0;
    content_name = 0;
    peer_address = 0;
    peer_port = 0;
    for (int i = 0; i < 6; i++) peer_pool[i] = (i == 0) ? '1 : rnd64();
    for (int i = 0; i < 4; i++) item_pool[i] = (i == 0) ? 64'h0 : rnd64();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    gaps_on = 1;
    test_backpressure();
    test_random();
    gaps_on = 0;
    test_random();
    repeat (40) @(negedge clk);
    if (errors == 0 && replies_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
